// File: hdl/rrts_pkg.sv
// Shared codes, field widths and stream layout of the round-robin task scheduler.
`default_nettype none
package rrts_pkg;

  localparam int OPCODE_W = 3;
  localparam int ID_W     = 16;
  localparam int RC_W     = 2;
  localparam int MODE_W   = 2;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  localparam logic [OPCODE_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_CREATE = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_PAUSE  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_RESUME = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_STOP   = 3'd4;

  localparam logic [RC_W-1:0] RC_OK        = 2'd0;
  localparam logic [RC_W-1:0] RC_FULL      = 2'd1;
  localparam logic [RC_W-1:0] RC_SYSTEM    = 2'd2;
  localparam logic [RC_W-1:0] RC_NOT_FOUND = 2'd3;

  localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACTIVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PAUSED = 2'd2;

endpackage
`default_nettype wire

// File: hdl/round_robin_task_scheduler.sv
// Round-robin task scheduler: slot table in RAM walked by a small sequencer.
// Short path: an unused opcode, a create with a full task count or id 0 goes
//   straight to the result state; the longest request is a stop of the current
//   task (id search, predecessor search and next-task walk, each stepping
//   through ring links). Flow: one request at a time; the next request is
//   taken in the cycle after the result is loaded, and a result still held by
//   a low out_tready holds the sequencer in its last state.
// Reset: rst_n is synchronous, active low; the system task comes up current
//   and active through per-slot valid bits, no clearing pass is needed.
`default_nettype none
module round_robin_task_scheduler #(
  parameter int MAX_TASKS = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // request channel
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [2:0] opcode, [18:3] task_id, [23:19] zero
  input  wire logic [rrts_pkg::IN_TDATA_W-1:0]   in_tdata,
  // result channel
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [1:0] result_code, [17:2] created_id, [33:18] running_id,
  // [34] switch_request, [39:35] zero
  output logic      [rrts_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  localparam int LW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [LW-1:0] LAST_SLOT = LW'(MAX_TASKS - 1);
  localparam logic [CW-1:0] MAX_CNT   = CW'(MAX_TASKS);

  // One slot of the task table.
  typedef struct packed {
    logic                          used;
    logic [rrts_pkg::MODE_W-1:0]   mode;
    logic [LW-1:0]                 link;
    logic [rrts_pkg::ID_W-1:0]     ident;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);
  localparam slot_t SLOT0_RESET = '{used: 1'b1, mode: rrts_pkg::MODE_ACTIVE,
                                    link: '0, ident: '0};

  typedef enum logic [4:0] {
    S_IDLE, S_TICK_RD, S_TICK_CHK, S_WALK_RD, S_WALK_CHK,
    S_FREE_RD, S_FREE_CHK, S_TAIL_RD, S_TAIL_CHK, S_NEW_WR,
    S_FIND_RD, S_FIND_CHK, S_PAUSE_FIN, S_RES_RD, S_RES_CHK, S_RES_ACT,
    S_PRED_RD, S_PRED_CHK, S_STOP_WR, S_DONE
  } state_t;

  // Sequencer state and registered outputs.
  state_t                        state_r, state_nxt;
  logic [rrts_pkg::OPCODE_W-1:0] op_r, op_nxt;
  logic [rrts_pkg::ID_W-1:0]     id_r, id_nxt;
  logic [LW-1:0]                 addr_r, addr_nxt;     // slot under the RAM read port
  logic [CW-1:0]                 steps_r, steps_nxt;   // links followed in this walk
  logic                          fallback_r, fallback_nxt;
  logic [LW-1:0]                 cur_r, cur_nxt;       // current slot
  logic [rrts_pkg::ID_W-1:0]     cur_ident_r, cur_ident_nxt;
  logic [CW-1:0]                 total_r, total_nxt;
  logic [rrts_pkg::ID_W-1:0]     idc_r, idc_nxt;       // next id to hand out
  logic [LW-1:0]                 fnd_r, fnd_nxt;       // slot named by the request
  slot_t                         fnd_ent_r, fnd_ent_nxt;
  logic [LW-1:0]                 free_r, free_nxt;     // slot taken by a create
  logic [rrts_pkg::RC_W-1:0]     rc_r, rc_nxt;
  logic [rrts_pkg::ID_W-1:0]     created_r, created_nxt;
  logic                          sw_r, sw_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [rrts_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // Per-slot valid bits: a slot never written reads as its reset contents.
  logic [MAX_TASKS-1:0]          valid_r;
  logic                          rd_valid_r;
  logic                          rd_zero_r;

  logic                          wr_en;
  logic [LW-1:0]                 wr_addr;
  slot_t                         wr_ent;
  logic [SLOT_W-1:0]             ram_rdata;
  slot_t                         ent;

  logic [rrts_pkg::OPCODE_W-1:0] in_opcode;
  logic [rrts_pkg::ID_W-1:0]     in_task_id;

  assign in_opcode  = in_tdata[2:0];
  assign in_task_id = in_tdata[18:3];

  rrts_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (MAX_TASKS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_ent),
    .rd_addr (addr_r),
    .rd_data (ram_rdata)
  );

  // Entry read in the previous cycle at addr_r, with the reset view applied.
  always_comb begin
    if (rd_valid_r) begin
      ent = slot_t'(ram_rdata);
    end else if (rd_zero_r) begin
      ent = SLOT0_RESET;
    end else begin
      ent = '0;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    addr_nxt      = addr_r;
    steps_nxt     = steps_r;
    fallback_nxt  = fallback_r;
    cur_nxt       = cur_r;
    cur_ident_nxt = cur_ident_r;
    total_nxt     = total_r;
    idc_nxt       = idc_r;
    fnd_nxt       = fnd_r;
    fnd_ent_nxt   = fnd_ent_r;
    free_nxt      = free_r;
    rc_nxt        = rc_r;
    created_nxt   = created_r;
    sw_nxt        = sw_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_addr       = addr_r;
    wr_ent        = ent;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt      = in_opcode;
          id_nxt      = in_task_id;
          rc_nxt      = rrts_pkg::RC_OK;
          created_nxt = '0;
          sw_nxt      = 1'b0;
          steps_nxt   = '0;
          unique case (in_opcode)
            rrts_pkg::OP_TICK: begin
              addr_nxt  = cur_r;
              state_nxt = S_TICK_RD;
            end
            rrts_pkg::OP_CREATE: begin
              if (total_r >= MAX_CNT) begin
                rc_nxt    = rrts_pkg::RC_FULL;
                state_nxt = S_DONE;
              end else begin
                addr_nxt  = LW'(1);
                state_nxt = S_FREE_RD;
              end
            end
            rrts_pkg::OP_PAUSE, rrts_pkg::OP_RESUME, rrts_pkg::OP_STOP: begin
              if (in_task_id == '0) begin
                rc_nxt    = rrts_pkg::RC_SYSTEM;
                state_nxt = S_DONE;
              end else begin
                addr_nxt  = '0;
                state_nxt = S_FIND_RD;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Tick: idle the current task, then walk from its successor.
      S_TICK_RD: state_nxt = S_TICK_CHK;
      S_TICK_CHK: begin
        wr_en        = 1'b1;
        wr_ent.mode  = rrts_pkg::MODE_IDLE;
        addr_nxt     = ent.link;
        steps_nxt    = '0;
        fallback_nxt = 1'b0;
        state_nxt    = S_WALK_RD;
      end

      // Walk: skip paused tasks, then make the landing slot active and current.
      S_WALK_RD: state_nxt = S_WALK_CHK;
      S_WALK_CHK: begin
        if ((ent.mode == rrts_pkg::MODE_PAUSED) && !fallback_r) begin
          if (steps_r < MAX_CNT) begin
            addr_nxt  = ent.link;
            steps_nxt = steps_r + CW'(1);
          end else begin
            addr_nxt     = '0;
            fallback_nxt = 1'b1;
          end
          state_nxt = S_WALK_RD;
        end else begin
          wr_en         = 1'b1;
          wr_ent.mode   = rrts_pkg::MODE_ACTIVE;
          cur_nxt       = addr_r;
          cur_ident_nxt = ent.ident;
          sw_nxt        = 1'b1;
          state_nxt     = (op_r == rrts_pkg::OP_PAUSE) ? S_PAUSE_FIN : S_DONE;
        end
      end

      // Create: lowest free slot, then the tail of the ring.
      S_FREE_RD: state_nxt = S_FREE_CHK;
      S_FREE_CHK: begin
        if (!ent.used) begin
          free_nxt  = addr_r;
          addr_nxt  = '0;
          steps_nxt = '0;
          state_nxt = S_TAIL_RD;
        end else if (addr_r == LAST_SLOT) begin
          rc_nxt    = rrts_pkg::RC_FULL;
          state_nxt = S_DONE;
        end else begin
          addr_nxt  = addr_r + LW'(1);
          state_nxt = S_FREE_RD;
        end
      end

      S_TAIL_RD: state_nxt = S_TAIL_CHK;
      S_TAIL_CHK: begin
        if ((ent.link != '0) && (steps_r < MAX_CNT)) begin
          addr_nxt  = ent.link;
          steps_nxt = steps_r + CW'(1);
          state_nxt = S_TAIL_RD;
        end else begin
          wr_en       = 1'b1;
          wr_ent.link = free_r;
          state_nxt   = S_NEW_WR;
        end
      end

      S_NEW_WR: begin
        wr_en        = 1'b1;
        wr_addr      = free_r;
        wr_ent.used  = 1'b1;
        wr_ent.mode  = rrts_pkg::MODE_IDLE;
        wr_ent.link  = '0;
        wr_ent.ident = idc_r;
        created_nxt  = idc_r;
        idc_nxt      = idc_r + rrts_pkg::ID_W'(1);
        total_nxt    = total_r + CW'(1);
        state_nxt    = S_DONE;
      end

      // Look up the named task in ring order from slot 0.
      S_FIND_RD: state_nxt = S_FIND_CHK;
      S_FIND_CHK: begin
        if (ent.used && (ent.ident == id_r)) begin
          fnd_nxt     = addr_r;
          fnd_ent_nxt = ent;
          if (addr_r == '0) begin
            rc_nxt    = rrts_pkg::RC_SYSTEM;
            state_nxt = S_DONE;
          end else begin
            unique case (op_r)
              rrts_pkg::OP_PAUSE: begin
                wr_en = 1'b1;
                if (addr_r == cur_r) begin
                  wr_ent.mode  = rrts_pkg::MODE_IDLE;
                  addr_nxt     = ent.link;
                  steps_nxt    = '0;
                  fallback_nxt = 1'b0;
                  state_nxt    = S_WALK_RD;
                end else begin
                  wr_ent.mode = rrts_pkg::MODE_PAUSED;
                  state_nxt   = S_DONE;
                end
              end
              rrts_pkg::OP_RESUME: begin
                addr_nxt  = cur_r;
                state_nxt = S_RES_RD;
              end
              default: begin
                addr_nxt  = '0;
                steps_nxt = '0;
                state_nxt = S_PRED_RD;
              end
            endcase
          end
        end else if (((CW+1)'(steps_r) + (CW+1)'(1)) < (CW+1)'(total_r)) begin
          addr_nxt  = ent.link;
          steps_nxt = steps_r + CW'(1);
          state_nxt = S_FIND_RD;
        end else begin
          rc_nxt    = rrts_pkg::RC_NOT_FOUND;
          state_nxt = S_DONE;
        end
      end

      // Pause of the current task: mark it paused after the walk.
      S_PAUSE_FIN: begin
        wr_en       = 1'b1;
        wr_addr     = fnd_r;
        wr_ent      = fnd_ent_r;
        wr_ent.mode = rrts_pkg::MODE_PAUSED;
        state_nxt   = S_DONE;
      end

      // Resume: idle the current task, then run the named one.
      S_RES_RD: state_nxt = S_RES_CHK;
      S_RES_CHK: begin
        wr_en       = 1'b1;
        wr_ent.mode = rrts_pkg::MODE_IDLE;
        state_nxt   = S_RES_ACT;
      end
      S_RES_ACT: begin
        wr_en         = 1'b1;
        wr_addr       = fnd_r;
        wr_ent        = fnd_ent_r;
        wr_ent.mode   = rrts_pkg::MODE_ACTIVE;
        cur_nxt       = fnd_r;
        cur_ident_nxt = fnd_ent_r.ident;
        sw_nxt        = 1'b1;
        state_nxt     = S_DONE;
      end

      // Stop: relink the predecessor past the slot, then free it.
      S_PRED_RD: state_nxt = S_PRED_CHK;
      S_PRED_CHK: begin
        if (ent.link == fnd_r) begin
          wr_en       = 1'b1;
          wr_ent.link = fnd_ent_r.link;
          state_nxt   = S_STOP_WR;
        end else if (((CW+1)'(steps_r) + (CW+1)'(1)) < (CW+1)'(MAX_CNT)) begin
          addr_nxt  = ent.link;
          steps_nxt = steps_r + CW'(1);
          state_nxt = S_PRED_RD;
        end else begin
          state_nxt = S_STOP_WR;
        end
      end

      S_STOP_WR: begin
        wr_en     = 1'b1;
        wr_addr   = fnd_r;
        wr_ent    = '0;
        total_nxt = total_r - CW'(1);
        if (fnd_r == cur_r) begin
          addr_nxt     = fnd_ent_r.link;
          steps_nxt    = '0;
          fallback_nxt = 1'b0;
          state_nxt    = S_WALK_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Hold the result until the output register is free.
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'b0, sw_r, cur_ident_r, created_r, rc_r};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      cur_ident_r <= '0;
      total_r     <= CW'(1);
      idc_r       <= rrts_pkg::ID_W'(1);
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      cur_ident_r <= cur_ident_nxt;
      total_r     <= total_nxt;
      idc_r       <= idc_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
    end
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    addr_r     <= addr_nxt;
    steps_r    <= steps_nxt;
    fallback_r <= fallback_nxt;
    fnd_r      <= fnd_nxt;
    fnd_ent_r  <= fnd_ent_nxt;
    free_r     <= free_nxt;
    rc_r       <= rc_nxt;
    created_r  <= created_nxt;
    sw_r       <= sw_nxt;
    out_data_r <= out_data_nxt;
    // Track the reset view alongside the RAM read of addr_r.
    rd_valid_r <= valid_r[addr_r];
    rd_zero_r  <= (addr_r == '0);
  end

endmodule
`default_nettype wire

// File: hdl/rrts_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
`default_nettype none
module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: tb/sv/sched_result_checker.sv
// Result checker for the round-robin task scheduler: predicts every result and compares it.
`timescale 1ns / 1ps
module sched_result_checker #(
  parameter int MAX_TASKS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  input  logic                                  in_tready,
  input  logic [rrts_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic [rrts_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output int                                    fail_count,
  output int                                    pending,
  output logic [MAX_TASKS-1:0]                  live_mask,
  output logic [MAX_TASKS*rrts_pkg::ID_W-1:0]   live_ids
);

  localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int ID_W   = rrts_pkg::ID_W;
  typedef logic [SLOT_W-1:0] slot_t;

  typedef struct packed {
    logic [rrts_pkg::RC_W-1:0] rc;
    logic [ID_W-1:0]           created;
    logic [ID_W-1:0]           running;
    logic                      sw;
  } sched_result_t;

  // Shadow of the task table.
  logic                          used_q  [MAX_TASKS];
  logic [ID_W-1:0]               ident_q [MAX_TASKS];
  logic [rrts_pkg::MODE_W-1:0]   mode_q  [MAX_TASKS];
  slot_t                         link_q  [MAX_TASKS];
  slot_t                         cur_slot;
  int                            task_count;
  logic [ID_W-1:0]               id_seq;

  sched_result_t                 expected_q [$];
  int                            mismatches;

  function automatic void clear_table();
    for (int s = 0; s < MAX_TASKS; s++) begin
      used_q[s]  = 1'b0;
      ident_q[s] = '0;
      mode_q[s]  = rrts_pkg::MODE_IDLE;
      link_q[s]  = '0;
    end
    used_q[0]  = 1'b1;
    mode_q[0]  = rrts_pkg::MODE_ACTIVE;
    cur_slot   = '0;
    task_count = 1;
    id_seq     = ID_W'(1);
  endfunction

  // Walk the ring from start, skip paused tasks, make the one found current.
  function automatic void switch_from(slot_t start);
    slot_t s;
    int    hops;
    s    = start;
    hops = 0;
    while (mode_q[s] == rrts_pkg::MODE_PAUSED && hops < MAX_TASKS) begin
      s = link_q[s];
      hops++;
    end
    if (mode_q[s] == rrts_pkg::MODE_PAUSED) s = '0;
    mode_q[s] = rrts_pkg::MODE_ACTIVE;
    cur_slot  = s;
  endfunction

  // First match in ring order from slot 0; MAX_TASKS when absent.
  function automatic int slot_of_id(logic [ID_W-1:0] id);
    slot_t s;
    s = '0;
    for (int i = 0; i < task_count && i < MAX_TASKS; i++) begin
      if (used_q[s] && ident_q[s] == id) return int'(s);
      s = link_q[s];
    end
    return MAX_TASKS;
  endfunction

  function automatic sched_result_t apply_request(logic [rrts_pkg::OPCODE_W-1:0] op,
                                                  logic [ID_W-1:0] id);
    sched_result_t r;
    int            s;
    slot_t         p;
    slot_t         succ;
    logic          relinked;
    r = '0;
    unique case (op)
      rrts_pkg::OP_TICK: begin
        mode_q[cur_slot] = rrts_pkg::MODE_IDLE;
        switch_from(link_q[cur_slot]);
        r.sw = 1'b1;
      end
      rrts_pkg::OP_CREATE: begin
        s = 1;
        while (s < MAX_TASKS && used_q[s]) s++;
        if (task_count >= MAX_TASKS || s >= MAX_TASKS) begin
          r.rc = rrts_pkg::RC_FULL;
        end else begin
          p = '0;
          for (int i = 0; i < MAX_TASKS && link_q[p] != 0; i++) p = link_q[p];
          link_q[p]  = slot_t'(s);
          link_q[s]  = '0;
          used_q[s]  = 1'b1;
          mode_q[s]  = rrts_pkg::MODE_IDLE;
          ident_q[s] = id_seq;
          r.created  = id_seq;
          id_seq     = id_seq + 1'b1;
          task_count++;
        end
      end
      rrts_pkg::OP_PAUSE, rrts_pkg::OP_RESUME, rrts_pkg::OP_STOP: begin
        s = (id == 0) ? 0 : slot_of_id(id);
        if (id == 0 || s == 0) begin
          r.rc = rrts_pkg::RC_SYSTEM;
        end else if (s >= MAX_TASKS) begin
          r.rc = rrts_pkg::RC_NOT_FOUND;
        end else if (op == rrts_pkg::OP_PAUSE) begin
          if (s == cur_slot) begin
            mode_q[cur_slot] = rrts_pkg::MODE_IDLE;
            switch_from(link_q[cur_slot]);
            r.sw = 1'b1;
          end
          mode_q[s] = rrts_pkg::MODE_PAUSED;
        end else if (op == rrts_pkg::OP_RESUME) begin
          mode_q[s]        = rrts_pkg::MODE_IDLE;
          mode_q[cur_slot] = rrts_pkg::MODE_IDLE;
          switch_from(slot_t'(s));
          r.sw = 1'b1;
        end else begin
          succ     = link_q[s];
          p        = '0;
          relinked = 1'b0;
          for (int i = 0; i < MAX_TASKS && !relinked; i++) begin
            if (link_q[p] == s) begin
              link_q[p] = succ;
              relinked  = 1'b1;
            end else begin
              p = link_q[p];
            end
          end
          used_q[s]  = 1'b0;
          mode_q[s]  = rrts_pkg::MODE_IDLE;
          ident_q[s] = '0;
          link_q[s]  = '0;
          if (task_count > 0) task_count--;
          if (s == cur_slot) begin
            switch_from(succ);
            r.sw = 1'b1;
          end
        end
      end
      default: ;
    endcase
    r.running = ident_q[cur_slot];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    sched_result_t                got;
    sched_result_t                want;
    logic [MAX_TASKS-1:0]         mask_v;
    logic [MAX_TASKS*ID_W-1:0]    ids_v;
    if (!rst_n) begin
      clear_table();
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_q.push_back(apply_request(in_tdata[rrts_pkg::OPCODE_W-1:0],
                                           in_tdata[rrts_pkg::OPCODE_W +: ID_W]));
      if (out_tvalid && out_tready) begin
        got.rc      = out_tdata[rrts_pkg::RC_W-1:0];
        got.created = out_tdata[rrts_pkg::RC_W +: ID_W];
        got.running = out_tdata[rrts_pkg::RC_W+ID_W +: ID_W];
        got.sw      = out_tdata[rrts_pkg::RC_W+2*ID_W];
        if (expected_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with no request waiting: %s",
                     $realtime,
                     $sformatf("rc=%0d created=%h running=%h sw=%0d",
                               got.rc, got.created, got.running, got.sw));
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (got.rc !== want.rc || got.created !== want.created ||
              got.running !== want.running || got.sw !== want.sw) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch: expected rc=%0d created=%h running=%h sw=%0d,",
                       $realtime, want.rc, want.created, want.running, want.sw);
              $display("    got rc=%0d created=%h running=%h sw=%0d",
                       got.rc, got.created, got.running, got.sw);
            end
            mismatches++;
          end
        end
      end
    end
    for (int s = 0; s < MAX_TASKS; s++) begin
      mask_v[s]              = used_q[s];
      ids_v[s*ID_W +: ID_W]  = ident_q[s];
    end
    fail_count   <= mismatches;
    pending      <= expected_q.size();
    live_mask    <= mask_v;
    live_ids     <= ids_v;
  end

endmodule

// File: tb/sv/tb_round_robin_task_scheduler.sv
// Testbench top for the round-robin task scheduler: request stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_round_robin_task_scheduler;

  localparam int MAX_TASKS = 8;
  localparam int ID_W      = rrts_pkg::ID_W;
  localparam int OPCODE_W  = rrts_pkg::OPCODE_W;
  // Extra wait at the end, twice the worst request time of the block.
  localparam int DRAIN_CYCLES = 2 * (6 * MAX_TASKS + 6);
  // Slowest correct run: about 1700 requests, each at worst latency plus a long receiver
  // stall and a long sender gap, stays well below this limit.
  localparam longint CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_PER_PHASE = 545;
  localparam logic [OPCODE_W-1:0] OP_UNUSED_TOP = OPCODE_W'((1 << OPCODE_W) - 1);

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  // [2:0] opcode, [18:3] task_id, [23:19] zero
  logic [rrts_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                     out_tvalid;
  logic                     out_tready;
  // [1:0] result_code, [17:2] created_id, [33:18] running_id, [34] switch_request
  logic [rrts_pkg::OUT_TDATA_W-1:0] out_tdata;

  int                       fail_count;
  int                       pending;
  logic [MAX_TASKS-1:0]     pred_mask;
  logic [MAX_TASKS*ID_W-1:0] pred_ids;

  int                       send_gap_pct;
  int                       recv_stall_pct = 58;
  longint                   cycle_count = 0;

  round_robin_task_scheduler #(.MAX_TASKS(MAX_TASKS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sched_result_checker #(.MAX_TASKS(MAX_TASKS)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .live_mask    (pred_mask),
    .live_ids     (pred_ids)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver side: stall at random with the current stall rate.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("round_robin_task_scheduler test failed");
      $finish;
    end
  end

  // Present one request, possibly after a random gap, and hold it until it is taken.
  // Valid stays high on return so back-to-back requests need no second assignment.
  task automatic send_req(input logic [OPCODE_W-1:0] op, input logic [ID_W-1:0] id);
    if ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(rrts_pkg::IN_TDATA_W-OPCODE_W-ID_W){1'b0}}, id, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold the sender until every predicted result has come back.
  // The first edge lets the checker count a request taken in this very step.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly ids of live tasks, so pause, resume and stop reach real work;
  // the rest is the system id and arbitrary 16-bit noise.
  function automatic logic [ID_W-1:0] pick_id();
    int roll;
    int base;
    int slot;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 28) return ID_W'($urandom_range(16'hFFFF));
    base = $urandom_range(MAX_TASKS - 1);
    for (int k = 0; k < MAX_TASKS; k++) begin
      slot = (base + k) % MAX_TASKS;
      if (slot != 0 && pred_mask[slot]) return pred_ids[slot*ID_W +: ID_W];
    end
    return ID_W'($urandom_range(1, 2 * MAX_TASKS));
  endfunction

  task automatic run_random(input int count);
    logic [OPCODE_W-1:0] op;
    int                  roll;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 28)      op = rrts_pkg::OP_TICK;
      else if (roll < 48) op = rrts_pkg::OP_CREATE;
      else if (roll < 62) op = rrts_pkg::OP_PAUSE;
      else if (roll < 76) op = rrts_pkg::OP_RESUME;
      else if (roll < 92) op = rrts_pkg::OP_STOP;
      else op = OPCODE_W'($urandom_range(rrts_pkg::OP_STOP + 1, OP_UNUSED_TOP));
      send_req(op, pick_id());
      // Occasionally let the block run dry mid-stream.
      if ($urandom_range(149) == 0) drain();
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    send_gap_pct = 24;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase 1: sender idles lightly, receiver heavily.
    // Directed requests first.
    send_req(rrts_pkg::OP_TICK, 16'hFFFF);    // lone system task: walk comes back to itself
    send_req(rrts_pkg::OP_PAUSE, 16'h0000);   // system task refused
    send_req(rrts_pkg::OP_PAUSE, 16'h1234);   // unknown ids
    send_req(rrts_pkg::OP_RESUME, 16'hFFFF);
    send_req(rrts_pkg::OP_STOP, 16'hAAAA);
    // fill the table, then overflow
    repeat (MAX_TASKS) send_req(rrts_pkg::OP_CREATE, 16'h5555);
    send_req(rrts_pkg::OP_TICK, 16'h0000);
    send_req(rrts_pkg::OP_TICK, 16'h0000);    // task 2 is current now
    send_req(rrts_pkg::OP_PAUSE, 16'd2);      // pause the current task: advance first
    send_req(rrts_pkg::OP_RESUME, 16'd2);
    send_req(rrts_pkg::OP_STOP, 16'd2);       // stop the current task: advance from its successor
    send_req(OP_UNUSED_TOP, 16'h00FF);        // unused opcode does nothing
    send_req(rrts_pkg::OP_PAUSE, 16'd4);
    send_req(rrts_pkg::OP_PAUSE, 16'd5);
    send_req(rrts_pkg::OP_TICK, 16'h0000);    // skip paused tasks
    send_req(rrts_pkg::OP_TICK, 16'h0000);
    send_req(rrts_pkg::OP_STOP, 16'd1);       // stop a task that is not current
    send_req(rrts_pkg::OP_CREATE, 16'h0000);  // reuse the freed slot, append at the tail
    drain();

    run_random(RANDOM_PER_PHASE);
    drain();

    // Phase 2: the other way round.
    send_gap_pct   = 58;
    recv_stall_pct <= 24;
    run_random(RANDOM_PER_PHASE);
    drain();

    // Phase 3: no idling.
    send_gap_pct   = 0;
    recv_stall_pct <= 0;
    run_random(RANDOM_PER_PHASE);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("round_robin_task_scheduler test passed");
    else
      $display("round_robin_task_scheduler test failed");
    $finish;
  end

endmodule
